// ===== design/tpc_pkg.sv =====
// shared types, constants and helpers for the triangle coverage core
package tpc_pkg;

  localparam int CoordW            = 16;
  localparam int DiffW             = CoordW + 1;
  localparam int ProdW             = 2 * DiffW;
  localparam int EdgeW             = ProdW + 1;
  localparam int MagW              = ProdW;
  localparam int SumW              = 64;
  localparam int RndMagW           = 61;
  localparam int AddrW             = 5;
  localparam int DataW             = 32;
  localparam int DefWeightFracBits = 14;

  localparam logic [2:0] REG_V0X = 3'd0;
  localparam logic [2:0] REG_V0Y = 3'd1;
  localparam logic [2:0] REG_V1X = 3'd2;
  localparam logic [2:0] REG_V1Y = 3'd3;
  localparam logic [2:0] REG_V2X = 3'd4;
  localparam logic [2:0] REG_V2Y = 3'd5;

  localparam logic [SumW-1:0]    CapTest = SumW'(1) << 59;
  localparam logic [RndMagW-1:0] CapVal  = RndMagW'(1) << 60;

  typedef struct packed {
    logic valid;
    logic cov;
    logic degen;
    logic neg0;
    logic neg1;
  } side_t;

  function automatic logic signed [CoordW-1:0] sat16(input logic signed [SumW-1:0] v);
    logic signed [CoordW-1:0] res;
    if (v > SumW'(32767)) begin
      res = 16'sh7fff;
    end else if (v < -SumW'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = v[CoordW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/triangle_pixel_coverage_barycentric_core.sv =====
// top level: triangle registers, edge front end, divider cell chain, output stage
//
// Takes one sample point per cycle while the pipeline advances and returns one coverage
// and weight result per point, in order. The pipeline length is set by the divider chain,
// one cell per quotient bit, both weight quotients sharing each cell. The whole pipeline
// advances whenever the output register is empty or being taken, so in_ready follows
// out_ready. Vertex registers sit at byte addresses 0x00..0x14 of the cfg port; the user
// must write them only while no point is in flight, and the block itself does not enforce
// this. Reads return the sign-extended value.
module triangle_pixel_coverage_barycentric_core #(
  parameter int WEIGHT_FRAC_BITS = tpc_pkg::DefWeightFracBits
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tpc_pkg::AddrW-1:0]           cfg_paddr,
  input  logic [tpc_pkg::DataW-1:0]           cfg_pwdata,
  output logic [tpc_pkg::DataW-1:0]           cfg_prdata,
  output logic                                cfg_pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tpc_pkg::CoordW-1:0]   in_point_x,
  input  logic signed [tpc_pkg::CoordW-1:0]   in_point_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_covered,
  output logic signed [tpc_pkg::CoordW-1:0]   out_weight0,
  output logic signed [tpc_pkg::CoordW-1:0]   out_weight1,
  output logic signed [tpc_pkg::CoordW-1:0]   out_weight2,
  output logic                                out_degenerate
);

  localparam int CW    = tpc_pkg::CoordW;
  localparam int MW    = tpc_pkg::MagW;
  localparam int QuotW = MW + WEIGHT_FRAC_BITS;
  localparam int NCell = QuotW;

  logic signed [CW-1:0] vtx_r [6];
  logic [2:0]           idx;
  logic                 wr;
  logic                 en;
  logic [CW-1:0]        rd;

  tpc_pkg::side_t            side_c [NCell+1];
  logic [MW-1:0]             d_c    [NCell+1];
  logic [1:0][MW-1:0]        r_c    [NCell+1];
  logic [1:0][QuotW-1:0]     nq_c   [NCell+1];
  logic [1:0][MW-1:0]        n_e;

  assign idx        = cfg_paddr[4:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) vtx_r[i] <= '0;
    end else if (wr) begin
      unique case (idx)
        tpc_pkg::REG_V0X: vtx_r[0] <= cfg_pwdata[CW-1:0];
        tpc_pkg::REG_V0Y: vtx_r[1] <= cfg_pwdata[CW-1:0];
        tpc_pkg::REG_V1X: vtx_r[2] <= cfg_pwdata[CW-1:0];
        tpc_pkg::REG_V1Y: vtx_r[3] <= cfg_pwdata[CW-1:0];
        tpc_pkg::REG_V2X: vtx_r[4] <= cfg_pwdata[CW-1:0];
        tpc_pkg::REG_V2Y: vtx_r[5] <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tpc_pkg::REG_V0X: rd = vtx_r[0];
      tpc_pkg::REG_V0Y: rd = vtx_r[1];
      tpc_pkg::REG_V1X: rd = vtx_r[2];
      tpc_pkg::REG_V1Y: rd = vtx_r[3];
      tpc_pkg::REG_V2X: rd = vtx_r[4];
      tpc_pkg::REG_V2Y: rd = vtx_r[5];
      default:          rd = '0;
    endcase
    cfg_prdata = {{(tpc_pkg::DataW-CW){rd[CW-1]}}, rd};
  end

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  tpc_edge u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .px       (in_point_x),
    .py       (in_point_y),
    .x0       (vtx_r[0]),
    .y0       (vtx_r[1]),
    .x1       (vtx_r[2]),
    .y1       (vtx_r[3]),
    .x2       (vtx_r[4]),
    .y2       (vtx_r[5]),
    .side_o   (side_c[0]),
    .d_o      (d_c[0]),
    .n_o      (n_e)
  );

  // chain head: empty remainder, dividend followed by the fraction zeros
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      r_c[0][i]  = '0;
      nq_c[0][i] = QuotW'(n_e[i]) << WEIGHT_FRAC_BITS;
    end
  end

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    tpc_div_cell #(
      .QuotW (QuotW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .side_i (side_c[g]),
      .d_i    (d_c[g]),
      .r_i    (r_c[g]),
      .nq_i   (nq_c[g]),
      .side_o (side_c[g+1]),
      .d_o    (d_c[g+1]),
      .r_o    (r_c[g+1]),
      .nq_o   (nq_c[g+1])
    );
  end

  tpc_post #(
    .WeightFracBits (WEIGHT_FRAC_BITS),
    .QuotW          (QuotW)
  ) u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .side_i         (side_c[NCell]),
    .d_i            (d_c[NCell]),
    .r_i            (r_c[NCell]),
    .q_i            (nq_c[NCell]),
    .out_valid      (out_valid),
    .out_covered    (out_covered),
    .out_weight0    (out_weight0),
    .out_weight1    (out_weight1),
    .out_weight2    (out_weight2),
    .out_degenerate (out_degenerate)
  );

endmodule

// ===== design/tpc_edge.sv =====
// edge functions, area, coverage test and operand magnitudes, four stages
module tpc_edge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [tpc_pkg::CoordW-1:0]    px,
  input  logic signed [tpc_pkg::CoordW-1:0]    py,
  input  logic signed [tpc_pkg::CoordW-1:0]    x0,
  input  logic signed [tpc_pkg::CoordW-1:0]    y0,
  input  logic signed [tpc_pkg::CoordW-1:0]    x1,
  input  logic signed [tpc_pkg::CoordW-1:0]    y1,
  input  logic signed [tpc_pkg::CoordW-1:0]    x2,
  input  logic signed [tpc_pkg::CoordW-1:0]    y2,
  output tpc_pkg::side_t                       side_o,
  output logic [tpc_pkg::MagW-1:0]             d_o,
  output logic [1:0][tpc_pkg::MagW-1:0]        n_o
);

  localparam int DW = tpc_pkg::DiffW;
  localparam int PW = tpc_pkg::ProdW;
  localparam int EW = tpc_pkg::EdgeW;
  localparam int MW = tpc_pkg::MagW;

  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: differences
  logic signed [DW-1:0] dx0_r, dy0_r, dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [DW-1:0] ex10_r, ey10_r, ex21_r, ey21_r, ex02_r, ey02_r;
  logic signed [DW-1:0] ex12_r, ey12_r, ex20_r, ey20_r;

  // stage 2: products
  logic signed [PW-1:0] pa_r [12];

  // stage 3: edge values
  logic signed [EW-1:0] s1_r, s2_r, s3_r, e0_r, e1_r, ar_r;

  // stage 4: magnitudes and flags
  logic [MW-1:0] d_r, n0_r, n1_r;
  logic          cov_r, degen_r, neg0_r, neg1_r;

  logic nonneg, nonpos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx0_r  <= DW'(px) - DW'(x0);
      dy0_r  <= DW'(py) - DW'(y0);
      dx1_r  <= DW'(px) - DW'(x1);
      dy1_r  <= DW'(py) - DW'(y1);
      dx2_r  <= DW'(px) - DW'(x2);
      dy2_r  <= DW'(py) - DW'(y2);
      ex10_r <= DW'(x1) - DW'(x0);
      ey10_r <= DW'(y1) - DW'(y0);
      ex21_r <= DW'(x2) - DW'(x1);
      ey21_r <= DW'(y2) - DW'(y1);
      ex02_r <= DW'(x0) - DW'(x2);
      ey02_r <= DW'(y0) - DW'(y2);
      ex12_r <= DW'(x1) - DW'(x2);
      ey12_r <= DW'(y1) - DW'(y2);
      ex20_r <= DW'(x2) - DW'(x0);
      ey20_r <= DW'(y2) - DW'(y0);

      pa_r[0]  <= PW'(dx0_r) * PW'(ey10_r);
      pa_r[1]  <= PW'(dy0_r) * PW'(ex10_r);
      pa_r[2]  <= PW'(dx1_r) * PW'(ey21_r);
      pa_r[3]  <= PW'(dy1_r) * PW'(ex21_r);
      pa_r[4]  <= PW'(dx2_r) * PW'(ey02_r);
      pa_r[5]  <= PW'(dy2_r) * PW'(ex02_r);
      pa_r[6]  <= PW'(dx2_r) * PW'(ey12_r);
      pa_r[7]  <= PW'(dy2_r) * PW'(ex12_r);
      pa_r[8]  <= PW'(dx0_r) * PW'(ey20_r);
      pa_r[9]  <= PW'(dy0_r) * PW'(ex20_r);
      pa_r[10] <= PW'(ex02_r) * PW'(ey12_r);
      pa_r[11] <= PW'(ey02_r) * PW'(ex12_r);

      s1_r <= EW'(pa_r[0]) - EW'(pa_r[1]);
      s2_r <= EW'(pa_r[2]) - EW'(pa_r[3]);
      s3_r <= EW'(pa_r[4]) - EW'(pa_r[5]);
      e0_r <= EW'(pa_r[6]) - EW'(pa_r[7]);
      e1_r <= EW'(pa_r[8]) - EW'(pa_r[9]);
      ar_r <= EW'(pa_r[10]) - EW'(pa_r[11]);

      d_r     <= MW'(ar_r[EW-1] ? -ar_r : ar_r);
      n0_r    <= MW'(e0_r[EW-1] ? -e0_r : e0_r);
      n1_r    <= MW'(e1_r[EW-1] ? -e1_r : e1_r);
      cov_r   <= nonneg || nonpos;
      degen_r <= (ar_r == '0);
      neg0_r  <= e0_r[EW-1] ^ ar_r[EW-1];
      neg1_r  <= e1_r[EW-1] ^ ar_r[EW-1];
    end
  end

  always_comb begin
    nonneg = !s1_r[EW-1] && !s2_r[EW-1] && !s3_r[EW-1];
    nonpos = (s1_r[EW-1] || s1_r == '0) && (s2_r[EW-1] || s2_r == '0)
          && (s3_r[EW-1] || s3_r == '0);
  end

  assign side_o = '{valid: v4_r, cov: cov_r, degen: degen_r, neg0: neg0_r, neg1: neg1_r};
  assign d_o    = d_r;
  assign n_o[0] = n0_r;
  assign n_o[1] = n1_r;

endmodule

// ===== design/tpc_div_cell.sv =====
// one restoring division step for both weight lanes
module tpc_div_cell #(
  parameter int QuotW = tpc_pkg::MagW + tpc_pkg::DefWeightFracBits
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  tpc_pkg::side_t                   side_i,
  input  logic [tpc_pkg::MagW-1:0]         d_i,
  input  logic [1:0][tpc_pkg::MagW-1:0]    r_i,
  input  logic [1:0][QuotW-1:0]            nq_i,
  output tpc_pkg::side_t                   side_o,
  output logic [tpc_pkg::MagW-1:0]         d_o,
  output logic [1:0][tpc_pkg::MagW-1:0]    r_o,
  output logic [1:0][QuotW-1:0]            nq_o
);

  localparam int MW = tpc_pkg::MagW;

  tpc_pkg::side_t            side_r;
  logic [MW-1:0]             d_r;
  logic [1:0][MW-1:0]        r_r, r_nxt;
  logic [1:0][QuotW-1:0]     nq_r, nq_nxt;
  logic [1:0][MW:0]          trial;
  logic [1:0]                ge;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i]  = {r_i[i], nq_i[i][QuotW-1]};
      ge[i]     = trial[i] >= {1'b0, d_i};
      r_nxt[i]  = ge[i] ? MW'(trial[i] - {1'b0, d_i}) : MW'(trial[i]);
      nq_nxt[i] = {nq_i[i][QuotW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= d_i;
      r_r  <= r_nxt;
      nq_r <= nq_nxt;
    end
  end

  assign side_o = side_r;
  assign d_o    = d_r;
  assign r_o    = r_r;
  assign nq_o   = nq_r;

endmodule

// ===== design/tpc_post.sv =====
// rounding, capping, sign, third weight, saturation and output register
module tpc_post #(
  parameter int WeightFracBits = tpc_pkg::DefWeightFracBits,
  parameter int QuotW          = tpc_pkg::MagW + tpc_pkg::DefWeightFracBits
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  tpc_pkg::side_t                      side_i,
  input  logic [tpc_pkg::MagW-1:0]            d_i,
  input  logic [1:0][tpc_pkg::MagW-1:0]       r_i,
  input  logic [1:0][QuotW-1:0]               q_i,
  output logic                                out_valid,
  output logic                                out_covered,
  output logic signed [tpc_pkg::CoordW-1:0]   out_weight0,
  output logic signed [tpc_pkg::CoordW-1:0]   out_weight1,
  output logic signed [tpc_pkg::CoordW-1:0]   out_weight2,
  output logic                                out_degenerate
);

  localparam int MW = tpc_pkg::MagW;
  localparam int SW = tpc_pkg::SumW;
  localparam int RW = tpc_pkg::RndMagW;
  localparam logic signed [SW-1:0] One = SW'(1) << WeightFracBits;

  tpc_pkg::side_t            sa_r, sb_r;
  logic [1:0][RW-1:0]        m_r, m_nxt;
  logic signed [SW-1:0]      sq0_r, sq1_r, q2;
  logic                      valid_r;
  logic                      cov_r, degen_r;
  logic signed [tpc_pkg::CoordW-1:0] w0_r, w1_r, w2_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (SW'(q_i[i]) >= tpc_pkg::CapTest) begin
        m_nxt[i] = tpc_pkg::CapVal;
      end else begin
        m_nxt[i] = RW'(q_i[i]) + RW'({r_i[i], 1'b0} >= {1'b0, d_i});
      end
    end
    q2 = One - sq0_r - sq1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r    <= '0;
      sb_r    <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      sa_r    <= side_i;
      sb_r    <= sa_r;
      valid_r <= sb_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= m_nxt;
      sq0_r   <= sa_r.neg0 ? -SW'(m_r[0]) : SW'(m_r[0]);
      sq1_r   <= sa_r.neg1 ? -SW'(m_r[1]) : SW'(m_r[1]);
      cov_r   <= sb_r.cov;
      degen_r <= sb_r.degen;
      w0_r    <= sb_r.degen ? '0 : tpc_pkg::sat16(sq0_r);
      w1_r    <= sb_r.degen ? '0 : tpc_pkg::sat16(sq1_r);
      w2_r    <= sb_r.degen ? '0 : tpc_pkg::sat16(q2);
    end
  end

  assign out_valid      = valid_r;
  assign out_covered    = cov_r;
  assign out_weight0    = w0_r;
  assign out_weight1    = w1_r;
  assign out_weight2    = w2_r;
  assign out_degenerate = degen_r;

endmodule

// ===== design/tpc_checker.sv =====
// port-level checks for the triangle coverage core, bound to the top level
module tpc_sva (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_covered,
  input logic signed [tpc_pkg::CoordW-1:0]  out_weight0,
  input logic signed [tpc_pkg::CoordW-1:0]  out_weight1,
  input logic signed [tpc_pkg::CoordW-1:0]  out_weight2,
  input logic                               out_degenerate
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_weight0) && $stable(out_weight1)
      && $stable(out_weight2) && $stable(out_covered) && $stable(out_degenerate))
    else $error("result changed while stalled");

  // zero area forces all weights to zero
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_weight0 == '0 && out_weight1 == '0
      && out_weight2 == '0)
    else $error("degenerate result with nonzero weight");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind triangle_pixel_coverage_barycentric_core tpc_sva u_tpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_covered    (out_covered),
  .out_weight0    (out_weight0),
  .out_weight1    (out_weight1),
  .out_weight2    (out_weight2),
  .out_degenerate (out_degenerate)
);

// ===== dv/tpc_checker.sv =====
// checker: watches point and result transfers, predicts coverage and weights, compares
module tpc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [tpc_pkg::AddrW-1:0] cfg_paddr,
  input  logic [tpc_pkg::DataW-1:0] cfg_pwdata,
  input  logic        cfg_pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_covered,
  input  logic signed [15:0] out_weight0,
  input  logic signed [15:0] out_weight1,
  input  logic signed [15:0] out_weight2,
  input  logic        out_degenerate,
  output int          fail_count,
  output int          pending,
  output int          covered_seen,
  output int          degen_seen
);

  typedef struct packed {
    logic cov;
    logic signed [15:0] w0;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic degen;
  } pixel_t;

  localparam int FracBits = tpc_pkg::DefWeightFracBits;

  logic signed [15:0] vtx [6];
  pixel_t expected_pixels [$];

  function automatic longint weight_div(longint num, longint den);
    logic neg;
    longint unsigned n, d, q, r;
    logic capped;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    capped = 0;
    for (int i = 0; i < FracBits; i++) begin
      if (q >= (64'd1 << 59)) begin
        capped = 1;
        break;
      end
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    if (capped || q >= (64'd1 << 59)) q = 64'd1 << 60;
    else if (2 * r >= d) q = q + 1;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic pixel_t predict_pixel(longint x, longint y);
    pixel_t p;
    longint x0, y0, x1, y1, x2, y2, s1, s2, s3, e0, e1, area, q0, q1;
    x0 = vtx[tpc_pkg::REG_V0X]; y0 = vtx[tpc_pkg::REG_V0Y];
    x1 = vtx[tpc_pkg::REG_V1X]; y1 = vtx[tpc_pkg::REG_V1Y];
    x2 = vtx[tpc_pkg::REG_V2X]; y2 = vtx[tpc_pkg::REG_V2Y];
    s1 = (x - x0) * (y1 - y0) - (y - y0) * (x1 - x0);
    s2 = (x - x1) * (y2 - y1) - (y - y1) * (x2 - x1);
    s3 = (x - x2) * (y0 - y2) - (y - y2) * (x0 - x2);
    p.cov = (s1 >= 0 && s2 >= 0 && s3 >= 0) || (s1 <= 0 && s2 <= 0 && s3 <= 0);
    e0 = (x - x2) * (y1 - y2) - (y - y2) * (x1 - x2);
    e1 = (x - x0) * (y2 - y0) - (y - y0) * (x2 - x0);
    area = (x0 - x2) * (y1 - y2) - (y0 - y2) * (x1 - x2);
    p.degen = area == 0;
    p.w0 = 0; p.w1 = 0; p.w2 = 0;
    if (area != 0) begin
      q0 = weight_div(e0, area);
      q1 = weight_div(e1, area);
      p.w0 = clamp16(q0);
      p.w1 = clamp16(q1);
      p.w2 = clamp16((longint'(1) << FracBits) - q0 - q1);
    end
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    covered_seen = 0;
    degen_seen = 0;
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) vtx[i] = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[4:2] < 6)
        vtx[cfg_paddr[4:2]] = cfg_pwdata[15:0];
      if (in_valid && in_ready)
        expected_pixels.push_back(predict_pixel(in_point_x, in_point_y));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_covered !== want.cov) report("covered", out_covered, want.cov);
          if (out_weight0 !== want.w0) report("weight0", out_weight0, want.w0);
          if (out_weight1 !== want.w1) report("weight1", out_weight1, want.w1);
          if (out_weight2 !== want.w2) report("weight2", out_weight2, want.w2);
          if (out_degenerate !== want.degen)
            report("degenerate", out_degenerate, want.degen);
          covered_seen += want.cov;
          degen_seen += want.degen;
        end
      end
    end
    pending = expected_pixels.size();
  end
endmodule

// ===== dv/triangle_pixel_coverage_barycentric_core_test.sv =====
// testbench top: drives triangles and sample points, holds off results, gives the verdict
module triangle_pixel_coverage_barycentric_core_test;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [tpc_pkg::AddrW-1:0] cfg_paddr = 0;
  logic [tpc_pkg::DataW-1:0] cfg_pwdata = 0;
  logic [tpc_pkg::DataW-1:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 0, in_ready;
  logic signed [15:0] in_point_x = 0, in_point_y = 0;
  logic out_valid, out_ready = 0;
  logic out_covered, out_degenerate;
  logic signed [15:0] out_weight0, out_weight1, out_weight2;
  int fail_count, pending, covered_seen, degen_seen;
  int long_hold = 0;
  int sent = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  triangle_pixel_coverage_barycentric_core dut (.*);
  tpc_checker chk (.*);

  // receiver: own stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (long_hold > 0) begin
      out_ready <= 0;
      long_hold <= long_hold - 1;
    end else begin
      case ((sent / 200) % 3)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  task automatic write_vertex(logic [2:0] idx, logic signed [15:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {{16{val[15]}}, val};
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic set_triangle(int x0, int y0, int x1, int y1, int x2, int y2);
    drain();
    write_vertex(tpc_pkg::REG_V0X, 16'(x0)); write_vertex(tpc_pkg::REG_V0Y, 16'(y0));
    write_vertex(tpc_pkg::REG_V1X, 16'(x1)); write_vertex(tpc_pkg::REG_V1Y, 16'(y1));
    write_vertex(tpc_pkg::REG_V2X, 16'(x2)); write_vertex(tpc_pkg::REG_V2Y, 16'(y2));
  endtask

  // one point transfer; valid stays up across back-to-back points when keep is set
  task automatic send_point(logic signed [15:0] px, logic signed [15:0] py, bit keep);
    in_valid <= 1; in_point_x <= px; in_point_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
    if (!keep) in_valid <= 0;
  endtask

  function automatic logic signed [15:0] near(int c, int span);
    int v;
    v = c + $signed($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic random_burst(int count, int span);
    int burst, cx, cy;
    cx = (chk.vtx[0] + chk.vtx[2] + chk.vtx[4]) / 3;
    cy = (chk.vtx[1] + chk.vtx[3] + chk.vtx[5]) / 3;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        if ($urandom_range(0, 7) == 0)
          send_point(16'($urandom), 16'($urandom), burst > 1 && count > 1);
        else
          send_point(near(cx, span), near(cy, span), burst > 1 && count > 1);
        burst--; count--;
      end
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  initial begin
    int sx [4] = '{-32768, 32767, 0, -1};
    repeat (10) @(negedge clk);
    rst_n <= 1;
    // reset triangle is degenerate at the origin
    send_point(0, 0, 0);
    send_point(16, 0, 0);
    set_triangle(0, 0, 1600, 0, 0, 1600);
    foreach (sx[i]) foreach (sx[j]) send_point(16'(sx[i]), 16'(sx[j]), 1);
    send_point(0, 0, 1); send_point(1600, 0, 1); send_point(0, 1600, 1);
    send_point(800, 800, 1); send_point(400, 400, 1); send_point(801, 801, 0);
    set_triangle(0, 0, 0, 1600, 1600, 0);
    send_point(400, 400, 1); send_point(-1, 5, 1); send_point(1, 1, 0);
    set_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
    send_point(32767, 32767, 1); send_point(-32768, -32768, 1); send_point(0, 0, 0);
    set_triangle(0, 0, 1, 0, 0, 1);
    send_point(-32768, 32767, 1); send_point(32767, 32767, 0);
    set_triangle(0, 0, 100, 100, 200, 200);
    send_point(50, 50, 1); send_point(50, 51, 0);
    for (int ph = 0; ph < 12; ph++) begin
      int span;
      span = (ph % 3 == 0) ? 32767 : (ph % 3 == 1) ? 2000 : 100;
      if (ph == 4)
        set_triangle(32767, 32767, -32768, 32767, 32767, -32768);
      else if (ph == 8)
        set_triangle($urandom_range(0, 40), 7, $urandom_range(0, 40), 7, 3, 7);
      else
        set_triangle(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom), int'($urandom));
      if (ph == 2) long_hold <= 300;
      random_burst(140, span);
    end
    drain();
    $display("sent %0d points over 12 triangles plus directed cases; %0d covered, %0d degenerate",
             sent, covered_seen, degen_seen);
    if (fail_count == 0)
      $display("triangle_pixel_coverage_barycentric_core_test passed");
    else
      $display("triangle_pixel_coverage_barycentric_core_test failed");
    $finish;
  end

  initial begin
    #400000;
    $display("triangle_pixel_coverage_barycentric_core_test failed");
    $finish;
  end
endmodule

// ===== files.f =====
design/tpc_pkg.sv
design/tpc_edge.sv
design/tpc_div_cell.sv
design/tpc_post.sv
design/triangle_pixel_coverage_barycentric_core.sv
design/tpc_checker.sv
dv/tpc_checker.sv
dv/triangle_pixel_coverage_barycentric_core_test.sv
